// ----- rtl/w2s_pkg.sv -----
// Shared types, widths and codes of the world-to-screen projector.
`timescale 1ns / 1ps
`default_nettype none
package w2s_pkg;

  // Fixed point format of matrix, points and screen coordinates
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 14;
  localparam int THR_W     = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  // Dot product: three floored products plus the column 3 element
  localparam int DOT_W = 2 * DATA_W - FRAC_BITS + 2;
  // Viewport scale W * 2^(FRAC_BITS-1)
  localparam int K_W   = DIM_W + FRAC_BITS - 1;
  // Dividend |dot| * k
  localparam int N_W   = DOT_W + K_W;
  localparam int LO_W  = (DOT_W + 1) / 2;
  localparam int HI_W  = DOT_W - LO_W;

  // Quotient capped at 2^CAP_LOG; QB quotient bits are developed
  localparam int CAP_LOG = 40;
  localparam int QB      = CAP_LOG + 1;
  localparam logic [QB-1:0] Q_CAP = {1'b1, {CAP_LOG{1'b0}}};

  // Divider latency: partial products, dividend sum, cap check, QB steps, clamp
  localparam int DIV_LAT = QB + 4;

  // Operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;
  localparam logic [THR_W-1:0] THRESH_RST = 31'd66;

  // Dot product results handed to the viewport stages
  typedef struct packed {
    logic                    valid;
    logic                    complete;
    logic signed [DOT_W-1:0] dot_x;
    logic signed [DOT_W-1:0] dot_y;
    logic signed [DOT_W-1:0] dot_w;
  } dot_out_t;

  // Control carried alongside the dividers
  typedef struct packed {
    logic valid;
    logic vis;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/world_to_screen_projector_core.sv -----
// Top level of the world-to-screen projector: viewport stages and output register.
//
// Usage: load the four rows of the world-to-projection matrix (Q16.16) with
// operation = load beats, one row each; these give no result. Each project
// beat carries a world point and gives exactly one result beat: visible and
// the screen position in pixels (Q16.16, saturated). Before all four rows are
// loaded, or when w is below w_threshold or not positive, the result is
// not visible with zero coordinates.
// Channels: in_valid/in_stall and out_valid/out_stall; a beat moves when
// valid is high and stall is low. The cfg port writes display_width,
// display_height and w_threshold; write it only while the block is empty.
// Pipeline: the product, sum, viewport and output stages around the 41-step
// pipelined divider.
// Throughput: one beat per cycle while no result is held by out_stall.
// Reset (synchronous, rst_n low) clears all valid bits, the loaded-row
// mask and the registers to their defaults; the matrix keeps its contents.
// A stalled result holds the whole pipeline, and in_stall follows it.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projector_core
  import w2s_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_operation,
  input  wire logic [1:0]               in_row_index,
  input  wire logic signed [DATA_W-1:0] in_row_col0,
  input  wire logic signed [DATA_W-1:0] in_row_col1,
  input  wire logic signed [DATA_W-1:0] in_row_col2,
  input  wire logic signed [DATA_W-1:0] in_row_col3,
  input  wire logic signed [DATA_W-1:0] in_point_x,
  input  wire logic signed [DATA_W-1:0] in_point_y,
  input  wire logic signed [DATA_W-1:0] in_point_z,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_visible,
  output logic signed [DATA_W-1:0]      out_screen_x,
  output logic signed [DATA_W-1:0]      out_screen_y
);

  localparam int T_W   = QB + 1;
  localparam int SUM_W = QB + 3;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [THR_W-1:0] thr_r;

  logic                     en;
  logic                     acc;
  logic signed [DATA_W-1:0] row_col [4];
  logic signed [DATA_W-1:0] point [3];
  dot_out_t                 dot_out;

  logic             v3_r;
  logic             vis3_r;
  logic             negx3_r;
  logic             negy3_r;
  logic [DOT_W-1:0] magx3_r;
  logic [DOT_W-1:0] magy3_r;
  logic [DOT_W-1:0] d3_r;
  logic             vis3_nxt;

  logic [K_W-1:0] kx;
  logic [K_W-1:0] ky;
  logic [QB-1:0]  qx;
  logic [QB-1:0]  qy;
  side_t          side_r [DIV_LAT];

  logic signed [T_W-1:0]    tx;
  logic signed [T_W-1:0]    ty;
  logic signed [SUM_W-1:0]  sx_full;
  logic signed [SUM_W-1:0]  sy_full;
  logic signed [DATA_W-1:0] sx_nxt;
  logic signed [DATA_W-1:0] sy_nxt;

  logic                     out_valid_r;
  logic                     out_visible_r;
  logic signed [DATA_W-1:0] out_screen_x_r;
  logic signed [DATA_W-1:0] out_screen_y_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thr_r    <= THRESH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_THRESH: thr_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished result is held
  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;
  assign acc      = in_valid && !in_stall;

  assign row_col[0] = in_row_col0;
  assign row_col[1] = in_row_col1;
  assign row_col[2] = in_row_col2;
  assign row_col[3] = in_row_col3;
  assign point[0]   = in_point_x;
  assign point[1]   = in_point_y;
  assign point[2]   = in_point_z;

  w2s_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .acc       (acc),
    .operation (in_operation),
    .row_index (in_row_index),
    .row_col   (row_col),
    .point     (point),
    .dot_out   (dot_out)
  );

  // Stage 3: visibility test, magnitudes and signs
  assign vis3_nxt = dot_out.complete && dot_out.dot_w > 0 &&
                    dot_out.dot_w >= $signed({{(DOT_W-THR_W){1'b0}}, thr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= dot_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis3_r  <= vis3_nxt;
      negx3_r <= dot_out.dot_x < 0;
      negy3_r <= dot_out.dot_y < 0;
      magx3_r <= (dot_out.dot_x < 0) ? DOT_W'(-dot_out.dot_x) : DOT_W'(dot_out.dot_x);
      magy3_r <= (dot_out.dot_y < 0) ? DOT_W'(-dot_out.dot_y) : DOT_W'(dot_out.dot_y);
      d3_r    <= DOT_W'(dot_out.dot_w);
    end
  end

  assign kx = K_W'(width_r) << (FRAC_BITS - 1);
  assign ky = K_W'(height_r) << (FRAC_BITS - 1);

  w2s_div u_div_x (
    .clk (clk),
    .en  (en),
    .mag (magx3_r),
    .k   (kx),
    .d   (d3_r),
    .q   (qx)
  );

  w2s_div u_div_y (
    .clk (clk),
    .en  (en),
    .mag (magy3_r),
    .k   (ky),
    .d   (d3_r),
    .q   (qy)
  );

  // Carry valid, visibility and signs alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[0] <= '{valid: v3_r, vis: vis3_r, neg_x: negx3_r, neg_y: negy3_r};
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Viewport offset and saturation
  always_comb begin
    tx      = side_r[DIV_LAT-1].neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    ty      = side_r[DIV_LAT-1].neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    sx_full = $signed({{(SUM_W-K_W){1'b0}}, kx}) + SUM_W'(tx);
    sy_full = $signed({{(SUM_W-K_W){1'b0}}, ky}) - SUM_W'(ty);
    priority if (sx_full > SUM_W'(32'sh7FFF_FFFF)) begin
      sx_nxt = 32'sh7FFF_FFFF;
    end else if (sx_full < SUM_W'(-33'sh8000_0000)) begin
      sx_nxt = -32'sh8000_0000;
    end else begin
      sx_nxt = DATA_W'(sx_full);
    end
    priority if (sy_full > SUM_W'(32'sh7FFF_FFFF)) begin
      sy_nxt = 32'sh7FFF_FFFF;
    end else if (sy_full < SUM_W'(-33'sh8000_0000)) begin
      sy_nxt = -32'sh8000_0000;
    end else begin
      sy_nxt = DATA_W'(sy_full);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_visible_r  <= side_r[DIV_LAT-1].vis;
      out_screen_x_r <= side_r[DIV_LAT-1].vis ? sx_nxt : '0;
      out_screen_y_r <= side_r[DIV_LAT-1].vis ? sy_nxt : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;

endmodule
`default_nettype wire

// ----- rtl/w2s_dot.sv -----
// Matrix store and two-stage dot product pipeline for rows 0, 1 and 3.
`timescale 1ns / 1ps
`default_nettype none
module w2s_dot
  import w2s_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     acc,
  input  wire logic                     operation,
  input  wire logic [1:0]               row_index,
  input  wire logic signed [DATA_W-1:0] row_col [4],
  input  wire logic signed [DATA_W-1:0] point [3],
  output dot_out_t                      dot_out
);

  logic        [DATA_W-1:0]   matrix_r [4][4];
  logic        [3:0]          rows_loaded_r;
  logic                       v1_r;
  logic                       complete1_r;
  logic signed [2*DATA_W-1:0] prod_r [3][3];
  logic signed [DATA_W-1:0]   col3_r [3];
  logic signed [DOT_W-1:0]    dot_nxt [3];
  dot_out_t                   dot_r;

  // Write a row on a load beat
  always_ff @(posedge clk) begin
    if (acc && operation == OP_LOAD) begin
      for (int c = 0; c < 4; c++) begin
        matrix_r[row_index][c] <= row_col[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r <= '0;
    end else if (acc && operation == OP_LOAD) begin
      rows_loaded_r[row_index] <= 1'b1;
    end
  end

  // Stage 1: products of rows 0, 1, 3 with the point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc && operation == OP_PROJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      complete1_r <= &rows_loaded_r;
      for (int c = 0; c < 3; c++) begin
        prod_r[0][c] <= $signed(matrix_r[0][c]) * point[c];
        prod_r[1][c] <= $signed(matrix_r[1][c]) * point[c];
        prod_r[2][c] <= $signed(matrix_r[3][c]) * point[c];
      end
      col3_r[0] <= $signed(matrix_r[0][3]);
      col3_r[1] <= $signed(matrix_r[1][3]);
      col3_r[2] <= $signed(matrix_r[3][3]);
    end
  end

  // Stage 2: floor each product and sum with the column 3 element
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_nxt[r] = DOT_W'(col3_r[r]);
      for (int c = 0; c < 3; c++) begin
        dot_nxt[r] = dot_nxt[r] + DOT_W'(prod_r[r][c] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r.valid <= 1'b0;
    end else if (en) begin
      dot_r.valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r.complete <= complete1_r;
      dot_r.dot_x    <= dot_nxt[0];
      dot_r.dot_y    <= dot_nxt[1];
      dot_r.dot_w    <= dot_nxt[2];
    end
  end

  assign dot_out = dot_r;

endmodule
`default_nettype wire

// ----- rtl/w2s_div.sv -----
// Pipelined scale-and-divide: floor(mag * k / d), capped at 2^CAP_LOG.
`timescale 1ns / 1ps
`default_nettype none
module w2s_div
  import w2s_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DOT_W-1:0] mag,
  input  wire logic [K_W-1:0]   k,
  input  wire logic [DOT_W-1:0] d,
  output logic      [QB-1:0]    q
);

  logic [LO_W+K_W-1:0] pl_r;
  logic [HI_W+K_W-1:0] ph_r;
  logic [DOT_W-1:0]    da_r;
  logic [N_W-1:0]      n_r;
  logic [DOT_W-1:0]    db_r;

  logic [DOT_W-1:0]    rem_r [QB+1];
  logic [QB-1:0]       low_r [QB+1];
  logic [QB-1:0]       quo_r [QB+1];
  logic [DOT_W-1:0]    dd_r  [QB+1];
  logic                cap_r [QB+1];
  logic [QB-1:0]       q_r;

  // Split the dividend product into two narrow partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= mag[LO_W-1:0] * k;
      ph_r <= mag[DOT_W-1:LO_W] * k;
      da_r <= d;
    end
  end

  // Combine the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= N_W'(pl_r) + (N_W'(ph_r) << LO_W);
      db_r <= da_r;
    end
  end

  // Flag a quotient of 2^QB or more; the upper dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      cap_r[0] <= DOT_W'(n_r[N_W-1:QB]) >= db_r;
      rem_r[0] <= DOT_W'(n_r[N_W-1:QB]);
      low_r[0] <= n_r[QB-1:0];
      quo_r[0] <= '0;
      dd_r[0]  <= db_r;
    end
  end

  // One quotient bit per stage, restoring
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DOT_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem_r[i], low_r[i][QB-1]};
      ge    = trial >= {1'b0, dd_r[i]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? DOT_W'(trial - {1'b0, dd_r[i]}) : DOT_W'(trial);
        low_r[i+1] <= {low_r[i][QB-2:0], 1'b0};
        quo_r[i+1] <= {quo_r[i][QB-2:0], ge};
        dd_r[i+1]  <= dd_r[i];
        cap_r[i+1] <= cap_r[i];
      end
    end
  end

  // Clamp to the cap
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= (cap_r[QB] || quo_r[QB] > Q_CAP) ? Q_CAP : quo_r[QB];
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ----- rtl/w2s_chk.sv -----
// Port-level checks of the projector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module w2s_chk
  import w2s_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     out_visible,
  input wire logic signed [DATA_W-1:0] out_screen_x,
  input wire logic signed [DATA_W-1:0] out_screen_y
);

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // Input is held exactly while a result is held
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held result");

  // Hidden points report zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == 0 && out_screen_y == 0)
    else $error("hidden point with nonzero coordinates");

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visible) &&
    $stable(out_screen_x) && $stable(out_screen_y))
    else $error("held result changed");

endmodule

bind world_to_screen_projector_core w2s_chk u_w2s_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_visible  (out_visible),
  .out_screen_x (out_screen_x),
  .out_screen_y (out_screen_y)
);
`default_nettype wire

// ----- bench/w2s_checker.sv -----
// Checker for the world-to-screen projector: predicts results and compares them.
`timescale 1ns / 1ps
module w2s_checker
  import w2s_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_operation,
  input  logic [1:0]               in_row_index,
  input  logic signed [DATA_W-1:0] in_row_col0,
  input  logic signed [DATA_W-1:0] in_row_col1,
  input  logic signed [DATA_W-1:0] in_row_col2,
  input  logic signed [DATA_W-1:0] in_row_col3,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_visible,
  input  logic signed [DATA_W-1:0] out_screen_x,
  input  logic signed [DATA_W-1:0] out_screen_y,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct packed {
    logic                    visible;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
  } pixel_t;

  pixel_t pixel_queue[$];
  logic signed [DATA_W-1:0] mat [16];
  logic [3:0] loaded_mask;
  logic [DIM_W-1:0] disp_w, disp_h;
  logic [THR_W-1:0] w_min;

  assign pending_count = pixel_queue.size();

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Dot product of one matrix row with (p, 1), products floored
  function automatic longint row_dot(input int r, input longint px, input longint py,
                                     input longint pz);
    longint acc;
    acc = longint'(mat[r*4+3]);
    acc += (longint'(mat[r*4+0]) * px) >>> FRAC_BITS;
    acc += (longint'(mat[r*4+1]) * py) >>> FRAC_BITS;
    acc += (longint'(mat[r*4+2]) * pz) >>> FRAC_BITS;
    return acc;
  endfunction

  // Viewport term dot*k/w, truncated toward zero, magnitude capped
  function automatic longint viewport_term(input longint num, input longint k, input longint w);
    logic [127:0] mag, q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag * 128'(k)) / 128'(w);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(input longint px, input longint py, input longint pz);
    pixel_t res;
    longint w, kx, ky;
    res = '0;
    if (loaded_mask != 4'hF) return res;
    w = row_dot(3, px, py, pz);
    if (w < longint'(w_min) || w <= 0) return res;
    kx = longint'(disp_w) << (FRAC_BITS - 1);
    ky = longint'(disp_h) << (FRAC_BITS - 1);
    res.visible = 1'b1;
    res.sx = clamp32(kx + viewport_term(row_dot(0, px, py, pz), kx, w));
    res.sy = clamp32(ky - viewport_term(row_dot(1, px, py, pz), ky, w));
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      loaded_mask <= '0;
      disp_w <= WIDTH_RST;
      disp_h <= HEIGHT_RST;
      w_min <= THRESH_RST;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WIDTH: begin
            disp_w <= cfg_wdata[DIM_W-1:0];
          end
          CFG_HEIGHT: begin
            disp_h <= cfg_wdata[DIM_W-1:0];
          end
          CFG_THRESH: begin
            w_min <= cfg_wdata[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // Predict on each accepted input beat
      if (in_valid && !in_stall) begin
        if (in_operation == OP_LOAD) begin
          mat[in_row_index*4+0] <= in_row_col0;
          mat[in_row_index*4+1] <= in_row_col1;
          mat[in_row_index*4+2] <= in_row_col2;
          mat[in_row_index*4+3] <= in_row_col3;
          loaded_mask[in_row_index] <= 1'b1;
        end else begin
          pixel_queue.push_back(project_point(longint'(in_point_x), longint'(in_point_y),
                                              longint'(in_point_z)));
        end
      end
      // Compare each accepted result beat
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = pixel_queue.pop_front();
          if (out_visible !== want.visible) report_mismatch("visible", out_visible, want.visible);
          if (out_screen_x !== want.sx) report_mismatch("screen_x", out_screen_x, want.sx);
          if (out_screen_y !== want.sy) report_mismatch("screen_y", out_screen_y, want.sy);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives the projector, sequences phases and prints the verdict.
`timescale 1ns / 1ps
module tb_top;
  import w2s_pkg::*;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_operation;
  logic [1:0] in_row_index;
  logic signed [DATA_W-1:0] in_row_col0, in_row_col1, in_row_col2, in_row_col3;
  logic signed [DATA_W-1:0] in_point_x, in_point_y, in_point_z;
  logic out_valid, out_stall, out_visible;
  logic signed [DATA_W-1:0] out_screen_x, out_screen_y;
  int fail_count, pending_count;
  int cycle_count;
  int send_idle_pct, recv_stall_pct;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  world_to_screen_projector_core DUT (.*);

  w2s_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on a runaway run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("world_to_screen_projector_core verification failed");
      $finish;
    end
  end

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return $urandom_range(8388608) - 4194304;
      default: return $urandom;
    endcase
  endfunction

  // Send one beat, holding it until accepted
  task automatic send_beat(input logic op, input logic [1:0] row,
                           input logic [31:0] c0, c1, c2, c3, px, py, pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_row_index <= row;
    in_row_col0 <= c0; in_row_col1 <= c1; in_row_col2 <= c2; in_row_col3 <= c3;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_row(input logic [1:0] row, input logic [31:0] c0, c1, c2, c3);
    send_beat(OP_LOAD, row, c0, c1, c2, c3, rand_word(), rand_word(), rand_word());
  endtask

  task automatic project(input logic [31:0] px, py, pz);
    send_beat(OP_PROJECT, 2'($urandom_range(3)), rand_word(), rand_word(), rand_word(),
              rand_word(), px, py, pz);
  endtask

  // Let the pipeline empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pulse one register write, then drop the enable again
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // A plausible camera matrix with random perturbation
  task automatic load_camera();
    load_row(0, 32'h00010000 + $urandom_range(8192), $urandom_range(4096) - 2048, 0,
             $urandom_range(65536) - 32768);
    load_row(1, 0, 32'h00010000 + $urandom_range(8192), $urandom_range(4096) - 2048,
             $urandom_range(65536) - 32768);
    load_row(2, 0, 0, 32'h00010000, 0);
    load_row(3, $urandom_range(2048) - 1024, $urandom_range(2048) - 1024, 32'h00010000,
             $urandom_range(131072));
  endtask

  initial begin
    int ph, n;
    logic [31:0] z;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_operation = 1'b0; in_row_index = '0;
    in_row_col0 = '0; in_row_col1 = '0; in_row_col2 = '0; in_row_col3 = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    out_stall = 1'b0; cycle_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: incomplete matrix, extremes, thresholds
    project(32'h00010000, 0, 32'h00050000);
    load_row(0, 32'h00010000, 0, 0, 0);
    load_row(1, 0, 32'h00010000, 0, 0);
    load_row(2, 0, 0, 32'h00010000, 0);
    project(32'h00010000, 0, 32'h00050000);
    load_row(3, 0, 0, 32'h00010000, 0);
    project(32'h00010000, 32'h00008000, 32'h00050000);
    project(0, 0, 0);
    project(0, 0, 32'hFFFF0000);
    project(32'h7FFFFFFF, 32'h80000000, 32'h00000041);
    project(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000042);
    project(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    load_row(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    load_row(3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    project(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    project(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    project(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    drain();
    // Zero threshold, zero w; extreme display sizes
    write_reg(CFG_THRESH, 0);
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 14'h3FFF);
    load_camera();
    project(0, 0, 0);
    project(32'h00010000, 32'h00010000, 32'h00020000);
    load_row(3, 0, 0, 0, 0);
    project(32'h00010000, 32'h00010000, 32'h00020000);
    drain();

    // Random phases through idling patterns and settings
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        0: begin write_reg(CFG_WIDTH, 1); write_reg(CFG_HEIGHT, 1); end
        1: begin write_reg(CFG_WIDTH, 8192); write_reg(CFG_HEIGHT, 8192); end
        2: begin write_reg(CFG_THRESH, 31'h7FFFFFFF); end
        3: begin write_reg(CFG_THRESH, 66); write_reg(CFG_WIDTH, 1920);
                 write_reg(CFG_HEIGHT, 1080); end
        default: begin
          write_reg(CFG_WIDTH, $urandom_range(16383));
          write_reg(CFG_HEIGHT, $urandom_range(16383));
          write_reg(CFG_THRESH, $urandom_range(3) == 0 ? $urandom : $urandom_range(70000));
        end
      endcase
      load_camera();
      for (n = 0; n < 142; n++) begin
        if ($urandom_range(9) == 0)
          load_row(2'($urandom_range(3)), rand_word(), rand_word(), rand_word(), rand_word());
        else if ($urandom_range(9) == 0)
          load_camera();
        else if ($urandom_range(4) == 0)
          project(rand_word(), rand_word(), rand_word());
        else begin
          z = 32'h00010000 + $urandom_range(32'h00800000);
          project($urandom_range(32'h01000000) - 32'h00800000,
                  $urandom_range(32'h01000000) - 32'h00800000, z);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("world_to_screen_projector_core verification clean");
    end else begin
      $display("world_to_screen_projector_core verification failed");
    end
    $finish;
  end

endmodule
